### hw/rtl/svm_pkg.sv
package svm_pkg;

	localparam int VOICES       = 32;
	localparam int QUEUE_DEPTH  = 1024;
	localparam int SAMPLE_WORDS = 65536;
	localparam int SLOTS        = 16;

	localparam int VIW    = (VOICES > 1) ? $clog2(VOICES) : 1;
	localparam int QIW    = $clog2(QUEUE_DEPTH);
	localparam int SAW    = $clog2(SAMPLE_WORDS);
	localparam int SIW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int ACC_W  = 16 + VIW + 1;
	localparam int QENT_W = 40 + 40 + 1 + 24 + 4;

	localparam logic [2:0] CMD_LOAD  = 3'd0;
	localparam logic [2:0] CMD_SLOT  = 3'd1;
	localparam logic [2:0] CMD_QUEUE = 3'd2;
	localparam logic [2:0] CMD_TICK  = 3'd3;
	localparam logic [2:0] CMD_PANIC = 3'd4;

	localparam logic [1:0] REG_OUT_CH  = 2'd0;
	localparam logic [1:0] REG_ATTACK  = 2'd1;
	localparam logic [1:0] REG_RELEASE = 2'd2;

	localparam logic [23:0] RATE_ONE  = 24'd65536;
	localparam logic [15:0] UNITY_Q15 = 16'd32768;

	typedef enum logic [2:0] {
		OP_LOAD  = 3'd0,
		OP_SLOT  = 3'd1,
		OP_QUEUE = 3'd2,
		OP_TICK  = 3'd3,
		OP_PANIC = 3'd4,
		OP_NOP   = 3'd5
	} op_t;

	typedef struct packed {
		op_t         op;
		logic [3:0]  slot;
		logic [15:0] addr;
		logic [15:0] value;
		logic [15:0] len;
		logic        stereo;
		logic [39:0] start;
		logic [23:0] rate;
		logic        pitched;
		logic [39:0] note_len;
	} cmd_t;

	typedef struct packed {
		logic [1:0]  out_channels;
		logic [15:0] attack_len;
		logic [15:0] release_len;
	} cfg_t;

endpackage

### hw/rtl/svm_req_if.sv
interface svm_req_if;
	logic               valid;
	logic               ready;
	logic [2:0]         cmd;
	logic [3:0]         sample_slot;
	logic [15:0]        mem_addr;
	logic signed [15:0] sample_value;
	logic [15:0]        length_frames;
	logic [1:0]         sample_channels;
	logic [39:0]        onset_frame;
	logic [23:0]        rate;
	logic               pitched;
	logic [39:0]        note_length;

	modport source(output valid, cmd, sample_slot, mem_addr, sample_value, length_frames,
		sample_channels, onset_frame, rate, pitched, note_length, input ready);
	modport sink(input valid, cmd, sample_slot, mem_addr, sample_value, length_frames,
		sample_channels, onset_frame, rate, pitched, note_length, output ready);
endinterface

### hw/rtl/svm_rsp_if.sv
interface svm_rsp_if;
	logic               valid;
	logic               ready;
	logic               status;
	logic signed [20:0] left_sum;
	logic signed [20:0] right_sum;

	modport source(output valid, status, left_sum, right_sum, input ready);
	modport sink(input valid, status, left_sum, right_sum, output ready);
endinterface

### hw/rtl/svm_front.sv
module svm_front (
	input  logic          clk,
	input  logic          arst_n,
	svm_req_if.sink       req,
	output logic          pop_valid,
	output svm_pkg::cmd_t pop_data,
	input  logic          pop
);
	import svm_pkg::*;

	cmd_t       ent_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;
	cmd_t       dec;
	logic       push;

	always_comb begin
		dec          = '0;
		dec.slot     = req.sample_slot;
		dec.addr     = req.mem_addr;
		dec.value    = req.sample_value;
		dec.len      = req.length_frames;
		dec.stereo   = req.sample_channels[1];
		dec.start    = req.onset_frame;
		// A zero rate plays at unit speed.
		dec.rate     = (req.rate == '0) ? RATE_ONE : req.rate;
		dec.pitched  = req.pitched;
		dec.note_len = req.note_length;
		case (req.cmd)
			CMD_LOAD:  dec.op = OP_LOAD;
			CMD_SLOT:  dec.op = OP_SLOT;
			CMD_QUEUE: dec.op = OP_QUEUE;
			CMD_TICK:  dec.op = OP_TICK;
			CMD_PANIC: dec.op = OP_PANIC;
			default:   dec.op = OP_NOP;
		endcase
	end

	assign req.ready = (cnt_q != 2'd2);
	assign push      = req.valid && req.ready;
	assign pop_valid = (cnt_q != 2'd0);
	assign pop_data  = ent_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wp_q] <= dec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= ~wp_q;
			end
			if (pop) begin
				rp_q <= ~rp_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end
endmodule

### hw/rtl/svm_div.sv
module svm_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [15:0] num,
	input  logic [15:0] den,
	output logic        done,
	output logic [15:0] quo
);
	// Computes floor(num * 32768 / den) for num <= den, one quotient bit a cycle.
	logic [15:0] r_q;
	logic [15:0] d_q;
	logic [15:0] q_q;
	logic [3:0]  cnt_q;
	logic        done_q;
	logic [16:0] r2;
	logic        ge;

	assign r2   = {r_q, 1'b0};
	assign ge   = (r2 >= {1'b0, d_q});
	assign done = done_q;
	assign quo  = q_q;

	always_ff @(posedge clk) begin
		if (start) begin
			d_q <= den;
			if (num >= den) begin
				r_q <= num - den;
				q_q <= 16'd1;
			end else begin
				r_q <= num;
				q_q <= 16'd0;
			end
		end else if (cnt_q != 4'd0) begin
			r_q <= ge ? 16'(r2 - {1'b0, d_q}) : r2[15:0];
			q_q <= {q_q[14:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= 4'd0;
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == 4'd1);
			if (start) begin
				cnt_q <= 4'd15;
			end else if (cnt_q != 4'd0) begin
				cnt_q <= cnt_q - 4'd1;
			end
		end
	end
endmodule

### hw/rtl/svm_back.sv
module svm_back (
	input  logic          clk,
	input  logic          arst_n,
	input  svm_pkg::cfg_t cfg,
	input  logic          pop_valid,
	input  svm_pkg::cmd_t pop_data,
	output logic          pop,
	svm_rsp_if.source     rsp
);
	import svm_pkg::*;

	typedef enum logic [17:0] {
		S_IDLE   = 18'h00001,
		S_EXEC   = 18'h00002,
		S_QRD    = 18'h00004,
		S_QCHK   = 18'h00008,
		S_VLOAD  = 18'h00010,
		S_MULA   = 18'h00020,
		S_MULB   = 18'h00040,
		S_POS    = 18'h00080,
		S_DIVA   = 18'h00100,
		S_RELCHK = 18'h00200,
		S_DIVR   = 18'h00400,
		S_RMUL   = 18'h00800,
		S_RD0    = 18'h01000,
		S_ACC0   = 18'h02000,
		S_ACC1   = 18'h04000,
		S_NEXT   = 18'h08000,
		S_FIN    = 18'h10000,
		S_RESP   = 18'h20000
	} state_t;

	state_t state_q;
	cmd_t   cur_q;

	logic [QIW-1:0] head_q;
	logic [QIW-1:0] tail_q;
	logic [39:0]    fr_q;

	logic [VOICES-1:0] vvalid_q;
	logic [3:0]        vslot_q   [VOICES];
	logic [23:0]       vrate_q   [VOICES];
	logic              vpitch_q  [VOICES];
	logic              vhasoff_q [VOICES];
	logic [39:0]       vstart_q  [VOICES];
	logic [39:0]       voff_q    [VOICES];

	logic [15:0] sbase_q   [SLOTS];
	logic [15:0] slen_q    [SLOTS];
	logic        sstereo_q [SLOTS];

	logic [QENT_W-1:0] qmem [QUEUE_DEPTH];
	logic [QENT_W-1:0] qrd_q;
	logic [15:0]       smem [SAMPLE_WORDS];
	logic [15:0]       smp_q;

	logic [VIW-1:0]          vidx_q;
	logic [39:0]             el_q;
	logic [43:0]             plo_q;
	logic [43:0]             phi_q;
	logic [15:0]             pos_q;
	logic [15:0]             amp_q;
	logic [15:0]             relg_q;
	logic [39:0]             rp_q;
	logic                    rel_q;
	logic signed [ACC_W-1:0] acc0_q;
	logic signed [ACC_W-1:0] acc1_q;

	logic        res_status_q;
	logic [20:0] res_left_q;
	logic [20:0] res_right_q;
	logic        out_valid_q;
	logic        out_status_q;
	logic [20:0] out_left_q;
	logic [20:0] out_right_q;

	// Queue entry fields.
	logic [39:0] q_start;
	logic [39:0] q_note;
	logic        q_pitched;
	logic [23:0] q_rate;
	logic [3:0]  q_slot;
	logic [QIW-1:0] head_nx;
	logic [QIW-1:0] tail_nx;
	logic        q_full;
	logic        q_due;

	logic [VIW-1:0] free_idx;
	logic           free_any;
	logic           v_we;

	logic [3:0]  vslot;
	logic        slot_ok;
	logic [15:0] d_base;
	logic [15:0] d_len;
	logic        d_stereo;
	logic [39:0] vstart;
	logic [39:0] voff;
	logic        nch2;
	logic [15:0] al;
	logic [15:0] rl;
	logic [64:0] full;
	logic [48:0] posw;
	logic [15:0] saddr0;
	logic [15:0] saddr1;
	logic        smem_re;
	logic [15:0] smem_ra;
	logic        smem_we;
	logic signed [32:0]      prod;
	logic signed [ACC_W-1:0] contrib;
	logic [31:0] amp_prod;

	logic        div_start;
	logic [15:0] div_n;
	logic [15:0] div_d;
	logic        div_done;
	logic [15:0] div_q;

	function automatic logic [20:0] sat21(input logic signed [ACC_W-1:0] a);
		logic signed [31:0] w;
		w = 32'(a);
		if (w > 32'sd1048575) begin
			return 21'h0FFFFF;
		end else if (w < -32'sd1048576) begin
			return 21'h100000;
		end
		return w[20:0];
	endfunction

	assign {q_start, q_note, q_pitched, q_rate, q_slot} = qrd_q;
	assign head_nx = (head_q == QIW'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;
	assign tail_nx = (tail_q == QIW'(QUEUE_DEPTH - 1)) ? '0 : tail_q + 1'b1;
	assign q_full  = (head_nx == tail_q);
	assign q_due   = (q_start <= fr_q);

	// Lowest free voice.
	always_comb begin
		free_idx = '0;
		free_any = 1'b0;
		for (int i = VOICES - 1; i >= 0; i--) begin
			if (!vvalid_q[i]) begin
				free_idx = VIW'(i);
				free_any = 1'b1;
			end
		end
	end

	assign v_we = (state_q == S_QCHK) && q_due && free_any;

	assign vslot    = vslot_q[vidx_q];
	assign slot_ok  = (32'(vslot) < SLOTS);
	assign d_base   = slot_ok ? sbase_q[vslot[SIW-1:0]] : 16'd0;
	assign d_len    = slot_ok ? slen_q[vslot[SIW-1:0]] : 16'd0;
	assign d_stereo = slot_ok ? sstereo_q[vslot[SIW-1:0]] : 1'b0;
	assign vstart   = vstart_q[vidx_q];
	assign voff     = voff_q[vidx_q];
	assign nch2     = cfg.out_channels[1];
	assign al       = (cfg.attack_len == '0) ? 16'd1 : cfg.attack_len;
	assign rl       = (cfg.release_len == '0) ? 16'd1 : cfg.release_len;

	// Read position from the two partial products of elapsed * rate.
	assign full = {1'b0, phi_q, 20'b0} + 65'(plo_q);
	assign posw = full[64:16];

	assign saddr0 = d_base + (d_stereo ? {pos_q[14:0], 1'b0} : pos_q);
	assign saddr1 = saddr0 + {15'b0, d_stereo};

	assign smem_re = (state_q == S_RD0) || ((state_q == S_ACC0) && nch2);
	assign smem_ra = (state_q == S_RD0) ? saddr0 : saddr1;
	assign smem_we = (state_q == S_EXEC) && (cur_q.op == OP_LOAD);

	assign prod     = $signed(smp_q) * $signed({1'b0, amp_q});
	assign contrib  = {{(ACC_W - 18){prod[32]}}, prod[32:15]};
	assign amp_prod = amp_q * relg_q;

	assign div_start = ((state_q == S_POS) && (posw < 49'(d_len)) && vpitch_q[vidx_q]
		&& (el_q < 40'(al)))
		|| ((state_q == S_RELCHK) && rel_q && (rp_q < 40'(rl)));
	assign div_n = (state_q == S_POS) ? el_q[15:0] : rl - rp_q[15:0];
	assign div_d = (state_q == S_POS) ? al : rl;

	svm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_n),
		.den    (div_d),
		.done   (div_done),
		.quo    (div_q)
	);

	assign pop = (state_q == S_IDLE) && pop_valid;

	assign rsp.valid     = out_valid_q;
	assign rsp.status    = out_status_q;
	assign rsp.left_sum  = out_left_q;
	assign rsp.right_sum = out_right_q;

	always_ff @(posedge clk) begin
		if (smem_we) begin
			smem[cur_q.addr[SAW-1:0]] <= cur_q.value;
		end
		if (smem_re) begin
			smp_q <= smem[smem_ra[SAW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_EXEC) && (cur_q.op == OP_QUEUE) && !q_full) begin
			qmem[head_q] <= {cur_q.start, cur_q.note_len, cur_q.pitched, cur_q.rate,
				cur_q.slot};
		end
		if ((state_q == S_QRD) && (tail_q != head_q)) begin
			qrd_q <= qmem[tail_q];
		end
	end

	always_ff @(posedge clk) begin
		if (v_we) begin
			vslot_q[free_idx]   <= q_slot;
			vrate_q[free_idx]   <= q_rate;
			vpitch_q[free_idx]  <= q_pitched;
			vhasoff_q[free_idx] <= q_pitched && (q_note != '0);
			vstart_q[free_idx]  <= q_start;
			voff_q[free_idx]    <= q_start + q_note;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (pop_valid) begin
					cur_q <= pop_data;
				end
			end
			S_VLOAD:  el_q  <= fr_q - vstart;
			S_MULA:   plo_q <= el_q[19:0] * vrate_q[vidx_q];
			S_MULB:   phi_q <= el_q[39:20] * vrate_q[vidx_q];
			S_POS: begin
				pos_q <= posw[15:0];
				amp_q <= UNITY_Q15;
				rp_q  <= fr_q - voff;
				rel_q <= vhasoff_q[vidx_q] && (fr_q >= voff);
			end
			S_DIVA: begin
				if (div_done) begin
					amp_q <= div_q;
				end
			end
			S_DIVR: begin
				if (div_done) begin
					relg_q <= div_q;
				end
			end
			S_RMUL:   amp_q <= amp_prod[30:15];
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			head_q       <= '0;
			tail_q       <= '0;
			fr_q         <= '0;
			vvalid_q     <= '0;
			vidx_q       <= '0;
			acc0_q       <= '0;
			acc1_q       <= '0;
			res_status_q <= 1'b0;
			res_left_q   <= '0;
			res_right_q  <= '0;
			out_valid_q  <= 1'b0;
			out_status_q <= 1'b0;
			out_left_q   <= '0;
			out_right_q  <= '0;
			for (int i = 0; i < SLOTS; i++) begin
				sbase_q[i]   <= '0;
				slen_q[i]    <= '0;
				sstereo_q[i] <= 1'b0;
			end
		end else begin
			if (rsp.valid && rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (pop_valid) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					res_status_q <= 1'b0;
					res_left_q   <= '0;
					res_right_q  <= '0;
					state_q      <= S_RESP;
					case (cur_q.op)
						OP_SLOT: begin
							if (32'(cur_q.slot) < SLOTS) begin
								sbase_q[cur_q.slot[SIW-1:0]]   <= cur_q.addr;
								slen_q[cur_q.slot[SIW-1:0]]    <= cur_q.len;
								sstereo_q[cur_q.slot[SIW-1:0]] <= cur_q.stereo;
							end
						end
						OP_QUEUE: begin
							if (q_full) begin
								res_status_q <= 1'b1;
							end else begin
								head_q <= head_nx;
							end
						end
						OP_PANIC: begin
							vvalid_q <= '0;
							tail_q   <= head_q;
						end
						OP_TICK: begin
							vidx_q  <= '0;
							acc0_q  <= '0;
							acc1_q  <= '0;
							state_q <= S_QRD;
						end
						default: begin
						end
					endcase
				end
				S_QRD: begin
					state_q <= (tail_q != head_q) ? S_QCHK : S_VLOAD;
				end
				S_QCHK: begin
					if (!q_due) begin
						state_q <= S_VLOAD;
					end else begin
						// With every voice busy the event is dropped.
						if (free_any) begin
							vvalid_q[free_idx] <= 1'b1;
						end
						tail_q  <= tail_nx;
						state_q <= S_QRD;
					end
				end
				S_VLOAD: begin
					if (!vvalid_q[vidx_q]) begin
						state_q <= S_NEXT;
					end else if (d_len == '0) begin
						vvalid_q[vidx_q] <= 1'b0;
						state_q          <= S_NEXT;
					end else if (fr_q < vstart) begin
						state_q <= S_NEXT;
					end else begin
						state_q <= S_MULA;
					end
				end
				S_MULA: state_q <= S_MULB;
				S_MULB: state_q <= S_POS;
				S_POS: begin
					if (posw >= 49'(d_len)) begin
						vvalid_q[vidx_q] <= 1'b0;
						state_q          <= S_NEXT;
					end else if (div_start) begin
						state_q <= S_DIVA;
					end else begin
						state_q <= S_RELCHK;
					end
				end
				S_DIVA: begin
					if (div_done) begin
						state_q <= S_RELCHK;
					end
				end
				S_RELCHK: begin
					if (!rel_q) begin
						state_q <= S_RD0;
					end else if (rp_q >= 40'(rl)) begin
						vvalid_q[vidx_q] <= 1'b0;
						state_q          <= S_NEXT;
					end else begin
						state_q <= S_DIVR;
					end
				end
				S_DIVR: begin
					if (div_done) begin
						state_q <= S_RMUL;
					end
				end
				S_RMUL: state_q <= S_RD0;
				S_RD0:  state_q <= S_ACC0;
				S_ACC0: begin
					acc0_q  <= acc0_q + contrib;
					state_q <= nch2 ? S_ACC1 : S_NEXT;
				end
				S_ACC1: begin
					acc1_q  <= acc1_q + contrib;
					state_q <= S_NEXT;
				end
				S_NEXT: begin
					if (vidx_q == VIW'(VOICES - 1)) begin
						state_q <= S_FIN;
					end else begin
						vidx_q  <= vidx_q + 1'b1;
						state_q <= S_VLOAD;
					end
				end
				S_FIN: begin
					res_left_q  <= sat21(acc0_q);
					res_right_q <= nch2 ? sat21(acc1_q) : 21'd0;
					fr_q        <= fr_q + 40'd1;
					state_q     <= S_RESP;
				end
				S_RESP: begin
					if (!out_valid_q || rsp.ready) begin
						out_valid_q  <= 1'b1;
						out_status_q <= res_status_q;
						out_left_q   <= res_left_q;
						out_right_q  <= res_right_q;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

### hw/rtl/sample_voice_mixer.sv
// A load, slot, queue, panic or unknown request passes from the execute state to the response
// state after acceptance. A tick also checks the event at the queue head, starts each due queue
// event, then visits every voice, idle or playing, with a second sample read for stereo output
// and envelope divisions where needed (divider: 1 bit per cycle).
// Throughput: the back end runs one request at a time; a 2-entry request queue and the output
// register let each side stall independently. Reset clears the queue pointers, frame counter,
// voice valid bits and slot table and loads the default registers; memories are not cleared.
module sample_voice_mixer (
	input  logic        clk,
	input  logic        arst_n,
	svm_req_if.sink     req,
	svm_rsp_if.source   rsp,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import svm_pkg::*;

	cfg_t cfg_q;
	logic pop_valid;
	cmd_t pop_data;
	logic pop;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.out_channels <= 2'd2;
			cfg_q.attack_len   <= 16'd240;
			cfg_q.release_len  <= 16'd1920;
		end else if (psel && penable && pwrite) begin
			case (paddr[3:2])
				REG_OUT_CH:  cfg_q.out_channels <= pwdata[1:0];
				REG_ATTACK:  cfg_q.attack_len   <= pwdata[15:0];
				REG_RELEASE: cfg_q.release_len  <= pwdata[15:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_OUT_CH:  prdata = {30'b0, cfg_q.out_channels};
			REG_ATTACK:  prdata = {16'b0, cfg_q.attack_len};
			REG_RELEASE: prdata = {16'b0, cfg_q.release_len};
			default:     prdata = 32'd0;
		endcase
	end

	svm_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.pop_valid (pop_valid),
		.pop_data  (pop_data),
		.pop       (pop)
	);

	svm_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.pop_valid (pop_valid),
		.pop_data  (pop_data),
		.pop       (pop),
		.rsp       (rsp)
	);
endmodule
